@@ design/four_corner_gradient_macros.svh @@
// ----------------------------------------------------------------------------
// four_corner_gradient macros
// Assertion shorthands for the gradient block, clocked on clk with rst_n reset.
// ----------------------------------------------------------------------------
`ifndef FOUR_CORNER_GRADIENT_MACROS_SVH
`define FOUR_CORNER_GRADIENT_MACROS_SVH

// same-cycle implication
`define FCG_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/fcg_pkg.sv @@
// ----------------------------------------------------------------------------
// fcg_pkg
// Widths, register indexes and reset values shared by the gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package fcg_pkg;

    // field widths
    localparam int PIX_W      = 12;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int CFG_DIM_W  = 13;
    localparam int COLOR_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // default dimension limit
    localparam int MAX_DIMENSION_DEF = 4096;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_ONE   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_TWO   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_THREE = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_FOUR  = CFG_IDX_W'(5);

    // register reset values
    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = CFG_DIM_W'(640);
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = CFG_DIM_W'(480);
    localparam logic [COLOR_W-1:0]   CORNER_RESET = '0;

endpackage

`default_nettype wire

@@ design/fcg_pixel_if.sv @@
// ----------------------------------------------------------------------------
// fcg_pixel_if
// Pixel coordinate channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcg_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [fcg_pkg::PIX_W-1:0] pixel_x;
    logic [fcg_pkg::PIX_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

@@ design/fcg_color_if.sv @@
// ----------------------------------------------------------------------------
// fcg_color_if
// Pixel color channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcg_color_if;
    logic                       valid;
    logic                       ready;
    logic [fcg_pkg::CHAN_W-1:0] red;
    logic [fcg_pkg::CHAN_W-1:0] green;
    logic [fcg_pkg::CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

@@ design/fcg_cfg_if.sv @@
// ----------------------------------------------------------------------------
// fcg_cfg_if
// Register write channel: index and data with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fcg_pkg::CFG_IDX_W-1:0]  index;
    logic [fcg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/fcg_divide.sv @@
// ----------------------------------------------------------------------------
// fcg_divide
// Pipelined restoring divider, one quotient bit per stage, for all color
// channels side by side. The quotient is known to fit in one channel.
// ----------------------------------------------------------------------------
`default_nettype none

module fcg_divide #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 26
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [NUM_W-1:0]            in_num [fcg_pkg::NUM_CHAN],
    input  wire logic [DEN_W-1:0]            den,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [fcg_pkg::CHAN_W-1:0]       out_quot [fcg_pkg::NUM_CHAN]
);

    localparam int Steps   = fcg_pkg::CHAN_W;
    localparam int NumChan = fcg_pkg::NUM_CHAN;

    logic [Steps-1:0]  valid_reg;
    logic [Steps-1:0]  adv;
    logic [NUM_W-1:0]  rem_reg  [Steps][NumChan];
    logic [Steps-1:0]  quot_reg [Steps][NumChan];

    // stage advance chain, a stage moves when it is empty or its successor moves
    always_comb
    begin
        adv[Steps-1] = !valid_reg[Steps-1] || out_ready;
        for (int s = Steps - 2; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
    end

    assign in_ready = adv[0];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int s = 1; s < Steps; s++)
            begin
                if (adv[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    // one trial subtract per stage, highest quotient bit first
    for (genvar s = 0; s < Steps; s++)
    begin : g_step
        localparam int Bit = Steps - 1 - s;

        logic [NUM_W-1:0] rem_in    [NumChan];
        logic [Steps-1:0] quot_in   [NumChan];
        logic [NUM_W-1:0] rem_next  [NumChan];
        logic [Steps-1:0] quot_next [NumChan];
        logic [NUM_W-1:0] shifted;

        assign shifted = NUM_W'(den) << Bit;

        for (genvar k = 0; k < NumChan; k++)
        begin : g_chan
            logic [NUM_W:0] diff;

            if (s == 0)
            begin : g_first
                assign rem_in[k]  = in_num[k];
                assign quot_in[k] = '0;
            end
            else
            begin : g_rest
                assign rem_in[k]  = rem_reg[s-1][k];
                assign quot_in[k] = quot_reg[s-1][k];
            end

            assign diff = {1'b0, rem_in[k]} - {1'b0, shifted};

            always_comb
            begin
                quot_next[k] = quot_in[k];
                quot_next[k][Bit] = !diff[NUM_W];
                rem_next[k] = diff[NUM_W] ? rem_in[k] : diff[NUM_W-1:0];
            end

            always_ff @(posedge clk)
            begin
                if (adv[s])
                begin
                    rem_reg[s][k]  <= rem_next[k];
                    quot_reg[s][k] <= quot_next[k];
                end
            end
        end
    end

    // last stage is the output register
    assign out_valid = valid_reg[Steps-1];

    always_comb
    begin
        for (int k = 0; k < NumChan; k++)
        begin
            out_quot[k] = quot_reg[Steps-1][k];
        end
    end

endmodule

`default_nettype wire

@@ design/four_corner_gradient.sv @@
// ----------------------------------------------------------------------------
// four_corner_gradient
// Bilinear four-corner color gradient: one RGB pixel for each coordinate beat.
// Each channel is floor((x*(y*c1 + (h-y)*c2) + (w-x)*(y*c3 + (h-y)*c4)) / (w*h)),
// with x clamped to w, y clamped to h, and w and h taken from the width and
// height registers (zero reads as one, values above MAX_DIMENSION as
// MAX_DIMENSION). The block takes one coordinate every cycle unless every
// stage is full and the output is held, and returns results in order:
// four stages clamp, blend the rows, multiply and sum, then eight divider
// stages produce one quotient bit each. Back pressure on the output fills
// empty stages before the input stalls. The user must write registers only
// while no pixel is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "four_corner_gradient_macros.svh"

module four_corner_gradient #(
    parameter int MAX_DIMENSION = fcg_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    fcg_cfg_if.sink       cfg,
    fcg_pixel_if.sink     pixel_in,
    fcg_color_if.source   color_out
);

    localparam int CfgDimW = fcg_pkg::CFG_DIM_W;
    localparam int PixW    = fcg_pkg::PIX_W;
    localparam int ChanW   = fcg_pkg::CHAN_W;
    localparam int NumChan = fcg_pkg::NUM_CHAN;
    localparam int ColorW  = fcg_pkg::COLOR_W;
    localparam int CfgMax  = (1 << CfgDimW) - 1;
    localparam int DimMax  = (MAX_DIMENSION > CfgMax) ? CfgMax : MAX_DIMENSION;
    localparam int DimW    = $clog2(DimMax + 1);
    localparam int CmpW    = (PixW > DimW) ? PixW : DimW;
    localparam int LeftW   = DimW + ChanW;
    localparam int NumW    = 2 * DimW + ChanW;
    localparam int DenW    = 2 * DimW;
    localparam int Front   = 4;
    localparam int Depth   = Front + ChanW;
    localparam int FlightW = $clog2(Depth + 1);

    // configuration registers
    logic [CfgDimW-1:0] width_reg;
    logic [CfgDimW-1:0] height_reg;
    logic [ColorW-1:0]  corner_one_reg;
    logic [ColorW-1:0]  corner_two_reg;
    logic [ColorW-1:0]  corner_three_reg;
    logic [ColorW-1:0]  corner_four_reg;

    logic [DimW-1:0] w_eff;
    logic [DimW-1:0] h_eff;
    logic [DenW-1:0] den_reg;

    // front pipeline control
    logic [Front-1:0] fv_reg;
    logic [Front-1:0] fadv;

    // stage 0: clamped coordinates and complements
    logic [DimW-1:0] x_next, y_next;
    logic [DimW-1:0] x0_reg, wx0_reg, y0_reg, hy0_reg;

    // stage 1: row colors
    logic [LeftW-1:0] left_next  [NumChan];
    logic [LeftW-1:0] right_next [NumChan];
    logic [LeftW-1:0] left_reg   [NumChan];
    logic [LeftW-1:0] right_reg  [NumChan];
    logic [DimW-1:0]  x1_reg, wx1_reg;

    // stage 2: column products
    logic [NumW-1:0] pa_reg [NumChan];
    logic [NumW-1:0] pb_reg [NumChan];

    // stage 3: full numerator
    logic [NumW-1:0] num_reg [NumChan];

    logic             div_in_ready;
    logic             div_out_valid;
    logic [ChanW-1:0] quot [NumChan];

    logic [FlightW-1:0] flight_reg;
    logic [FlightW-1:0] flight_next;
    logic               in_beat;
    logic               out_beat;

    // register writes, unknown indexes ignored
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= fcg_pkg::WIDTH_RESET;
            height_reg       <= fcg_pkg::HEIGHT_RESET;
            corner_one_reg   <= fcg_pkg::CORNER_RESET;
            corner_two_reg   <= fcg_pkg::CORNER_RESET;
            corner_three_reg <= fcg_pkg::CORNER_RESET;
            corner_four_reg  <= fcg_pkg::CORNER_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                fcg_pkg::REG_IMAGE_WIDTH:  width_reg        <= cfg.data[CfgDimW-1:0];
                fcg_pkg::REG_IMAGE_HEIGHT: height_reg       <= cfg.data[CfgDimW-1:0];
                fcg_pkg::REG_CORNER_ONE:   corner_one_reg   <= cfg.data[ColorW-1:0];
                fcg_pkg::REG_CORNER_TWO:   corner_two_reg   <= cfg.data[ColorW-1:0];
                fcg_pkg::REG_CORNER_THREE: corner_three_reg <= cfg.data[ColorW-1:0];
                fcg_pkg::REG_CORNER_FOUR:  corner_four_reg  <= cfg.data[ColorW-1:0];
                default: ;
            endcase
        end
    end

    // dimension limits: zero reads as one, oversize as the maximum
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DimW'(1);
        else if (width_reg > CfgDimW'(DimMax))
            w_eff = DimW'(DimMax);
        else
            w_eff = DimW'(width_reg);

        if (height_reg == '0)
            h_eff = DimW'(1);
        else if (height_reg > CfgDimW'(DimMax))
            h_eff = DimW'(DimMax);
        else
            h_eff = DimW'(height_reg);
    end

    // divisor w*h follows the registers, registered from the limited dimensions
    always_ff @(posedge clk)
    begin
        den_reg <= DenW'(w_eff) * DenW'(h_eff);
    end

    // front stage advance chain
    always_comb
    begin
        fadv[Front-1] = !fv_reg[Front-1] || div_in_ready;
        for (int s = Front - 2; s >= 0; s--)
        begin
            fadv[s] = !fv_reg[s] || fadv[s+1];
        end
    end

    assign pixel_in.ready = fadv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else
        begin
            if (fadv[0])
            begin
                fv_reg[0] <= pixel_in.valid;
            end
            for (int s = 1; s < Front; s++)
            begin
                if (fadv[s])
                begin
                    fv_reg[s] <= fv_reg[s-1];
                end
            end
        end
    end

    // coordinate clamp
    always_comb
    begin
        if (CmpW'(pixel_in.pixel_x) > CmpW'(w_eff))
            x_next = w_eff;
        else
            x_next = DimW'(pixel_in.pixel_x);

        if (CmpW'(pixel_in.pixel_y) > CmpW'(h_eff))
            y_next = h_eff;
        else
            y_next = DimW'(pixel_in.pixel_y);
    end

    // row blends per channel, red in the top byte
    always_comb
    begin
        for (int k = 0; k < NumChan; k++)
        begin
            left_next[k] =
                LeftW'(y0_reg) * LeftW'(corner_one_reg[(NumChan-1-k)*ChanW +: ChanW]) +
                LeftW'(hy0_reg) * LeftW'(corner_two_reg[(NumChan-1-k)*ChanW +: ChanW]);
            right_next[k] =
                LeftW'(y0_reg) * LeftW'(corner_three_reg[(NumChan-1-k)*ChanW +: ChanW]) +
                LeftW'(hy0_reg) * LeftW'(corner_four_reg[(NumChan-1-k)*ChanW +: ChanW]);
        end
    end

    // front payload registers
    always_ff @(posedge clk)
    begin
        if (fadv[0])
        begin
            x0_reg  <= x_next;
            wx0_reg <= w_eff - x_next;
            y0_reg  <= y_next;
            hy0_reg <= h_eff - y_next;
        end
        if (fadv[1])
        begin
            x1_reg  <= x0_reg;
            wx1_reg <= wx0_reg;
            for (int k = 0; k < NumChan; k++)
            begin
                left_reg[k]  <= left_next[k];
                right_reg[k] <= right_next[k];
            end
        end
        if (fadv[2])
        begin
            for (int k = 0; k < NumChan; k++)
            begin
                pa_reg[k] <= NumW'(x1_reg) * NumW'(left_reg[k]);
                pb_reg[k] <= NumW'(wx1_reg) * NumW'(right_reg[k]);
            end
        end
        if (fadv[3])
        begin
            for (int k = 0; k < NumChan; k++)
            begin
                num_reg[k] <= pa_reg[k] + pb_reg[k];
            end
        end
    end

    // divide by w*h
    fcg_divide #(
        .NUM_W (NumW),
        .DEN_W (DenW)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fv_reg[Front-1]),
        .in_ready  (div_in_ready),
        .in_num    (num_reg),
        .den       (den_reg),
        .out_valid (div_out_valid),
        .out_ready (color_out.ready),
        .out_quot  (quot)
    );

    assign color_out.valid = div_out_valid;
    assign color_out.red   = quot[0];
    assign color_out.green = quot[1];
    assign color_out.blue  = quot[2];

    // beats in flight
    assign in_beat  = pixel_in.valid && pixel_in.ready;
    assign out_beat = color_out.valid && color_out.ready;

    always_comb
    begin
        flight_next = flight_reg + FlightW'(in_beat) - FlightW'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flight_reg <= '0;
        else
            flight_reg <= flight_next;
    end

    // input stalls only when every stage holds a beat and the output is held
    `FCG_ASSERT_IMPLIES(a_stall_only_when_full, !pixel_in.ready, color_out.valid && !color_out.ready, "input stalled with room in the pipeline")
    // a result never appears without an accepted coordinate behind it
    `FCG_ASSERT_IMPLIES(a_result_has_source, color_out.valid, flight_reg != '0, "result with no beat in flight")
    // occupancy never exceeds the stage count
    `FCG_ASSERT_NEXT(a_flight_bound, 1'b1, flight_reg <= FlightW'(Depth), "more beats in flight than stages")

endmodule

`default_nettype wire
